// ----- hw/rtl/spring_beam_force_with_break_defines.svh -----
// ----------------------------------------------------------------------------
// spring beam force assertion macros
// shared property wrappers clocked on aclk, disabled during reset
// ----------------------------------------------------------------------------
`ifndef SPRING_BEAM_FORCE_WITH_BREAK_DEFINES_SVH
`define SPRING_BEAM_FORCE_WITH_BREAK_DEFINES_SVH

// same-cycle implication
`define SBF_ASSERT_NOW(label, ant, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ant) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define SBF_ASSERT_NEXT(label, ant, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ant) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- hw/rtl/sbf_pkg.sv -----
// ----------------------------------------------------------------------------
// sbf_pkg
// widths, codes and step functions for the spring beam force pipeline
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sbf_pkg;

    localparam int CW      = 24;
    localparam int FB      = 8;
    localparam int REST_W  = 24;
    localparam int STIFF_W = 24;
    localparam int MPL_W   = 16;
    localparam int GRAV_W  = 24;
    localparam int OUT_W   = 40;
    localparam int RATIO_W = 17;
    localparam int UFRAC   = 16;

    localparam int N_W         = 2 * CW + 2;
    localparam int ROOT_W      = CW + 1;
    localparam int REM_W       = CW + 3;
    localparam int SQRT_STAGES = CW + 1;

    localparam int DV_W       = (CW + 1 > STIFF_W) ? CW + 1 : STIFF_W;
    localparam int Q_W        = UFRAC + 1;
    localparam int DIV_STAGES = Q_W;

    localparam int MAG_W    = STIFF_W + ROOT_W - FB;
    localparam int MAGSAT_W = OUT_W - 1;
    localparam int MASS_W   = MPL_W + REST_W - 16;
    localparam int HW_W     = MASS_W + GRAV_W - FB - 1;

    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 24;
    localparam logic [CFG_IDX_W-1:0] REG_STIFFNESS   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BREAK_FORCE = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MASS_PER_L  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GRAVITY     = 8'd3;

    localparam logic [1:0] MODE_END_A   = 2'd0;
    localparam logic [1:0] MODE_END_B   = 2'd1;
    localparam logic [1:0] MODE_NEITHER = 2'd2;
    localparam logic [1:0] MODE_UNUSED  = 2'd3;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        logic [N_W-1:0]    n;
    } sqrt_st_t;

    typedef struct packed {
        logic [DV_W-1:0] rem;
        logic [DV_W-1:0] y;
        logic [Q_W-1:0]  bits;
        logic [Q_W-1:0]  q;
    } div_st_t;

    // one radix-2 digit of the integer square root
    function automatic sqrt_st_t sqrt_step(input sqrt_st_t s);
        logic [REM_W-1:0] sh;
        logic [REM_W-1:0] t;
        sqrt_st_t r;
        sh = {s.rem[ROOT_W-1:0], s.n[N_W-1:N_W-2]};
        t  = {s.root, 2'b01};
        r.n = {s.n[N_W-3:0], 2'b00};
        if (sh >= t) begin
            r.rem  = sh - t;
            r.root = {s.root[ROOT_W-2:0], 1'b1};
        end else begin
            r.rem  = sh;
            r.root = {s.root[ROOT_W-2:0], 1'b0};
        end
        return r;
    endfunction

    // one restoring division step
    function automatic div_st_t div_step(input div_st_t s);
        logic [DV_W:0] sh;
        div_st_t r;
        sh     = {s.rem, s.bits[Q_W-1]};
        r.y    = s.y;
        r.bits = {s.bits[Q_W-2:0], 1'b0};
        if (sh >= {1'b0, s.y}) begin
            r.rem = DV_W'(sh - {1'b0, s.y});
            r.q   = {s.q[Q_W-2:0], 1'b1};
        end else begin
            r.rem = sh[DV_W-1:0];
            r.q   = {s.q[Q_W-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage

// ----- hw/rtl/sbf_sqrt.sv -----
// ----------------------------------------------------------------------------
// sbf_sqrt
// pipelined integer square root, one result digit per stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sbf_sqrt (
    input  logic                       aclk,
    input  logic                       en,
    input  logic [sbf_pkg::N_W-1:0]    n,
    output logic [sbf_pkg::ROOT_W-1:0] root
);

    sbf_pkg::sqrt_st_t st_reg [sbf_pkg::SQRT_STAGES];
    sbf_pkg::sqrt_st_t init;

    always_comb begin
        init.rem  = '0;
        init.root = '0;
        init.n    = n;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st_reg[0] <= sbf_pkg::sqrt_step(init);
            for (int i = 1; i < sbf_pkg::SQRT_STAGES; i++) begin
                st_reg[i] <= sbf_pkg::sqrt_step(st_reg[i-1]);
            end
        end
    end

    assign root = st_reg[sbf_pkg::SQRT_STAGES-1].root;

endmodule

// ----- hw/rtl/sbf_div.sv -----
// ----------------------------------------------------------------------------
// sbf_div
// pipelined divider, q = (x << 16) / y, one quotient bit per stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sbf_div (
    input  logic                     aclk,
    input  logic                     en,
    input  logic [sbf_pkg::DV_W-1:0] x,
    input  logic [sbf_pkg::DV_W-1:0] y,
    output logic [sbf_pkg::Q_W-1:0]  q
);

    sbf_pkg::div_st_t st_reg [sbf_pkg::DIV_STAGES];
    sbf_pkg::div_st_t init;

    // x >> 1 is below y, so only the low quotient bits are live
    always_comb begin
        init.rem  = x >> 1;
        init.y    = y;
        init.bits = {x[0], {(sbf_pkg::Q_W-1){1'b0}}};
        init.q    = '0;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st_reg[0] <= sbf_pkg::div_step(init);
            for (int i = 1; i < sbf_pkg::DIV_STAGES; i++) begin
                st_reg[i] <= sbf_pkg::div_step(st_reg[i-1]);
            end
        end
    end

    assign q = st_reg[sbf_pkg::DIV_STAGES-1].q;

endmodule

// ----- hw/rtl/spring_beam_force_with_break.sv -----
// ----------------------------------------------------------------------------
// spring_beam_force_with_break
// 2d spring beam force with half weight and break ratio, fully pipelined
// ----------------------------------------------------------------------------
// channel   dir  handshake            payload
// s_        in   s_tvalid/s_tready    tdata end coords + rest, tuser mode
// m_        out  m_tvalid/m_tready    tdata force_x/y + ratio, tuser flags
// cfg_      in   cfg_valid/cfg_ready  register index + data
//
// one word per cycle while the output is not stalled; the pipeline depth is set by the
// one-digit-per-stage sqrt and divider pipelines
// the whole pipe advances together; when the output word is stalled every
// stage holds, so nothing is lost or repeated
// reset clears the valid chain and loads the default register values
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "spring_beam_force_with_break_defines.svh"

module spring_beam_force_with_break (
    input  logic                          aclk,
    input  logic                          aresetn,
    // end_a_x, end_a_y, end_b_x, end_b_y, rest_length
    input  logic [119:0]                  s_tdata,
    // mode
    input  logic [1:0]                    s_tuser,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // force_x, force_y, stress_ratio, zero pad
    output logic [103:0]                  m_tdata,
    // broken, valid_res
    output logic [1:0]                    m_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [sbf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sbf_pkg::CFG_DAT_W-1:0] cfg_data
);

    localparam int CW  = sbf_pkg::CW;
    localparam int SQN = sbf_pkg::SQRT_STAGES;
    localparam int DVN = sbf_pkg::DIV_STAGES;

    // payload carried alongside the sqrt
    typedef struct packed {
        logic [CW-1:0]               adx;
        logic [CW-1:0]               ady;
        logic                        nx;
        logic                        ny;
        logic [sbf_pkg::REST_W-1:0]  rest;
        logic [1:0]                  mode;
        logic [sbf_pkg::HW_W-1:0]    hw;
    } geo_t;

    // payload carried alongside the dividers
    typedef struct packed {
        logic [sbf_pkg::MAGSAT_W-1:0] magsat;
        logic                         ns;
        logic                         nx;
        logic                         ny;
        logic                         zrest;
        logic [1:0]                   mode;
        logic [sbf_pkg::HW_W-1:0]     hw;
        logic                         brk;
        logic                         bfon;
    } frc_t;

    // ---------------- configuration registers ----------------
    logic [sbf_pkg::STIFF_W-1:0] stiff_reg;
    logic [sbf_pkg::STIFF_W-1:0] bf_reg;
    logic [sbf_pkg::MPL_W-1:0]   mpl_reg;
    logic [sbf_pkg::GRAV_W-1:0]  grav_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stiff_reg <= 24'd256000;
            bf_reg    <= 24'd512000;
            mpl_reg   <= 16'd655;
            grav_reg  <= 24'd2511;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                sbf_pkg::REG_STIFFNESS:   stiff_reg <= cfg_data;
                sbf_pkg::REG_BREAK_FORCE: bf_reg    <= cfg_data;
                sbf_pkg::REG_MASS_PER_L:  mpl_reg   <= cfg_data[sbf_pkg::MPL_W-1:0];
                sbf_pkg::REG_GRAVITY:     grav_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    logic                        g_neg;
    logic [sbf_pkg::GRAV_W-1:0]  g_abs;
    assign g_neg = grav_reg[sbf_pkg::GRAV_W-1];
    assign g_abs = g_neg ? (~grav_reg + 1'b1) : grav_reg;

    // global advance: the pipe moves whenever the output slot is free
    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // ---------------- stage a: input capture ----------------
    logic               v_a_reg;
    logic [CW-1:0]      ax_reg, ay_reg, bx_reg, by_reg;
    logic [23:0]        rest_a_reg;
    logic [1:0]         mode_a_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) v_a_reg <= 1'b0;
        else if (en)  v_a_reg <= s_tvalid;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ax_reg     <= s_tdata[23:0];
            ay_reg     <= s_tdata[47:24];
            bx_reg     <= s_tdata[71:48];
            by_reg     <= s_tdata[95:72];
            rest_a_reg <= s_tdata[119:96];
            mode_a_reg <= s_tuser;
        end
    end

    // ---------------- stage b: differences, mass product ----------------
    logic signed [CW:0] dx_s, dy_s;
    logic               v_b_reg;
    geo_t               g_b_reg;
    logic [39:0]        mprod_reg;

    assign dx_s = $signed({ax_reg[CW-1], ax_reg}) - $signed({bx_reg[CW-1], bx_reg});
    assign dy_s = $signed({ay_reg[CW-1], ay_reg}) - $signed({by_reg[CW-1], by_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) v_b_reg <= 1'b0;
        else if (en)  v_b_reg <= v_a_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            g_b_reg.nx   <= dx_s[CW];
            g_b_reg.ny   <= dy_s[CW];
            g_b_reg.adx  <= dx_s[CW] ? CW'(-dx_s) : CW'(dx_s);
            g_b_reg.ady  <= dy_s[CW] ? CW'(-dy_s) : CW'(dy_s);
            g_b_reg.rest <= rest_a_reg;
            g_b_reg.mode <= mode_a_reg;
            g_b_reg.hw   <= '0;
            mprod_reg    <= mpl_reg * rest_a_reg;
        end
    end

    // ---------------- stage c: squares, mass ----------------
    logic                          v_c_reg;
    geo_t                          g_c_reg;
    logic [2*CW-1:0]               sqx_reg, sqy_reg;
    logic [sbf_pkg::MASS_W-1:0]    mass_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) v_c_reg <= 1'b0;
        else if (en)  v_c_reg <= v_b_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            g_c_reg  <= g_b_reg;
            sqx_reg  <= g_b_reg.adx * g_b_reg.adx;
            sqy_reg  <= g_b_reg.ady * g_b_reg.ady;
            mass_reg <= mprod_reg[39:16];
        end
    end

    // ---------------- stage d: sum of squares, half weight ----------------
    logic                   v_d_reg;
    geo_t                   g_d_reg;
    geo_t                   g_d_next;
    logic [sbf_pkg::N_W-1:0] nsum_reg;
    logic [47:0]            hprod;

    assign hprod = mass_reg * g_abs;

    always_comb begin
        g_d_next    = g_c_reg;
        g_d_next.hw = hprod[47:sbf_pkg::FB+1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) v_d_reg <= 1'b0;
        else if (en)  v_d_reg <= v_c_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            g_d_reg    <= g_d_next;
            nsum_reg   <= sbf_pkg::N_W'(sqx_reg) + sbf_pkg::N_W'(sqy_reg);
        end
    end

    // ---------------- sqrt pipeline ----------------
    logic [sbf_pkg::ROOT_W-1:0] len_root;
    logic [SQN-1:0]             v_sq_reg;
    geo_t                       g_sq_reg [SQN];

    sbf_sqrt u_sqrt (
        .aclk (aclk),
        .en   (en),
        .n    (nsum_reg),
        .root (len_root)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) v_sq_reg <= '0;
        else if (en)  v_sq_reg <= {v_sq_reg[SQN-2:0], v_d_reg};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            g_sq_reg[0] <= g_d_reg;
            for (int i = 1; i < SQN; i++) g_sq_reg[i] <= g_sq_reg[i-1];
        end
    end

    // ---------------- stage e: stretch ----------------
    logic                       v_e_reg;
    geo_t                       g_e_reg;
    logic [sbf_pkg::ROOT_W-1:0] len_reg, sabs_reg;
    logic                       ns_reg;
    logic [sbf_pkg::ROOT_W-1:0] rest_ext;

    assign rest_ext = sbf_pkg::ROOT_W'(g_sq_reg[SQN-1].rest);

    always_ff @(posedge aclk) begin
        if (!aresetn) v_e_reg <= 1'b0;
        else if (en)  v_e_reg <= v_sq_reg[SQN-1];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            g_e_reg  <= g_sq_reg[SQN-1];
            len_reg  <= len_root;
            ns_reg   <= len_root < rest_ext;
            sabs_reg <= (len_root < rest_ext) ? rest_ext - len_root : len_root - rest_ext;
        end
    end

    // ---------------- stage f: force magnitude ----------------
    logic                         v_f_reg;
    geo_t                         g_f_reg;
    logic [sbf_pkg::ROOT_W-1:0]   len_f_reg;
    logic                         ns_f_reg;
    logic [sbf_pkg::MAG_W-1:0]    mag_reg;
    logic [sbf_pkg::MAG_W+sbf_pkg::FB-1:0] kprod;

    assign kprod = stiff_reg * sabs_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) v_f_reg <= 1'b0;
        else if (en)  v_f_reg <= v_e_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            g_f_reg   <= g_e_reg;
            len_f_reg <= len_reg;
            ns_f_reg  <= ns_reg;
            // zero length gives zero spring force
            mag_reg   <= (len_reg == '0) ? '0 : kprod[sbf_pkg::MAG_W+sbf_pkg::FB-1:sbf_pkg::FB];
        end
    end

    // ---------------- divider setup ----------------
    logic                       lenz, bfon, brk;
    logic [sbf_pkg::DV_W-1:0]   ux_x, uy_x, u_y, r_x, r_y;
    logic [sbf_pkg::Q_W-1:0]    ux_q, uy_q, r_q;
    frc_t                       f_in;

    assign lenz = (len_f_reg == '0);
    assign bfon = (bf_reg != '0);
    assign brk  = bfon && (mag_reg >= sbf_pkg::MAG_W'(bf_reg));
    assign ux_x = lenz ? '0 : sbf_pkg::DV_W'(g_f_reg.adx);
    assign uy_x = lenz ? '0 : sbf_pkg::DV_W'(g_f_reg.ady);
    assign u_y  = lenz ? sbf_pkg::DV_W'(1) : sbf_pkg::DV_W'(len_f_reg);
    assign r_x  = (bfon && !brk) ? sbf_pkg::DV_W'(mag_reg) : '0;
    assign r_y  = bfon ? sbf_pkg::DV_W'(bf_reg) : sbf_pkg::DV_W'(1);

    always_comb begin
        f_in.magsat = (mag_reg[sbf_pkg::MAG_W-1:sbf_pkg::MAGSAT_W] != '0) ?
                      '1 : mag_reg[sbf_pkg::MAGSAT_W-1:0];
        f_in.ns     = ns_f_reg;
        f_in.nx     = g_f_reg.nx;
        f_in.ny     = g_f_reg.ny;
        f_in.zrest  = (g_f_reg.rest == '0);
        f_in.mode   = g_f_reg.mode;
        f_in.hw     = g_f_reg.hw;
        f_in.brk    = brk;
        f_in.bfon   = bfon;
    end

    sbf_div u_div_ux (.aclk(aclk), .en(en), .x(ux_x), .y(u_y), .q(ux_q));
    sbf_div u_div_uy (.aclk(aclk), .en(en), .x(uy_x), .y(u_y), .q(uy_q));
    sbf_div u_div_r  (.aclk(aclk), .en(en), .x(r_x),  .y(r_y), .q(r_q));

    logic [DVN-1:0] v_dv_reg;
    frc_t           f_dv_reg [DVN];

    always_ff @(posedge aclk) begin
        if (!aresetn) v_dv_reg <= '0;
        else if (en)  v_dv_reg <= {v_dv_reg[DVN-2:0], v_f_reg};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f_dv_reg[0] <= f_in;
            for (int i = 1; i < DVN; i++) f_dv_reg[i] <= f_dv_reg[i-1];
        end
    end

    // ---------------- stage h: directed components ----------------
    logic                         v_h_reg;
    frc_t                         f_h_reg;
    logic [sbf_pkg::OUT_W-1:0]    cx_reg, cy_reg;
    logic [sbf_pkg::RATIO_W-1:0]  ratio_reg;
    logic [sbf_pkg::MAGSAT_W+sbf_pkg::Q_W-1:0] cxp, cyp;

    assign cxp = f_dv_reg[DVN-1].magsat * ux_q;
    assign cyp = f_dv_reg[DVN-1].magsat * uy_q;

    always_ff @(posedge aclk) begin
        if (!aresetn) v_h_reg <= 1'b0;
        else if (en)  v_h_reg <= v_dv_reg[DVN-1];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f_h_reg   <= f_dv_reg[DVN-1];
            cx_reg    <= cxp[sbf_pkg::MAGSAT_W+sbf_pkg::Q_W-1:sbf_pkg::UFRAC];
            cy_reg    <= cyp[sbf_pkg::MAGSAT_W+sbf_pkg::Q_W-1:sbf_pkg::UFRAC];
            ratio_reg <= f_dv_reg[DVN-1].brk ? sbf_pkg::RATIO_W'(65536) :
                         (f_dv_reg[DVN-1].bfon ? r_q : '0);
        end
    end

    // ---------------- stage i: sign, weight, saturate ----------------
    localparam int SW = sbf_pkg::OUT_W + 2;
    localparam logic signed [SW-1:0] OMAX = SW'(64'sd549755813887);
    localparam logic signed [SW-1:0] OMIN = -SW'(64'sd549755813888);

    logic signed [SW-1:0] sx, sy, half, fx_raw, fy_raw;
    logic [sbf_pkg::OUT_W-1:0] fx_sat, fy_sat;

    always_comb begin
        sx   = $signed({2'b00, cx_reg});
        sy   = $signed({2'b00, cy_reg});
        half = $signed(SW'(f_h_reg.hw));
        if (f_h_reg.ns != f_h_reg.nx) sx = -sx;
        if (f_h_reg.ns != f_h_reg.ny) sy = -sy;
        if (g_neg) half = -half;
        if (f_h_reg.mode == sbf_pkg::MODE_END_A) begin
            fx_raw = -sx;
            fy_raw = -sy + half;
        end else begin
            fx_raw = sx;
            fy_raw = sy + half;
        end
        if (fx_raw > OMAX)      fx_sat = OMAX[sbf_pkg::OUT_W-1:0];
        else if (fx_raw < OMIN) fx_sat = OMIN[sbf_pkg::OUT_W-1:0];
        else                    fx_sat = fx_raw[sbf_pkg::OUT_W-1:0];
        if (fy_raw > OMAX)      fy_sat = OMAX[sbf_pkg::OUT_W-1:0];
        else if (fy_raw < OMIN) fy_sat = OMIN[sbf_pkg::OUT_W-1:0];
        else                    fy_sat = fy_raw[sbf_pkg::OUT_W-1:0];
        // mode neither or unused: no force reported
        if (f_h_reg.mode != sbf_pkg::MODE_END_A && f_h_reg.mode != sbf_pkg::MODE_END_B) begin
            fx_sat = '0;
            fy_sat = '0;
        end
    end

    logic                         v_i_reg;
    logic [sbf_pkg::OUT_W-1:0]    fx_reg, fy_reg;
    logic [sbf_pkg::RATIO_W-1:0]  ratio_i_reg;
    logic                         brk_i_reg, vres_i_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) v_i_reg <= 1'b0;
        else if (en)  v_i_reg <= v_h_reg;
    end

    // zero rest length: whole word is zero
    always_ff @(posedge aclk) begin
        if (en) begin
            fx_reg      <= f_h_reg.zrest ? '0 : fx_sat;
            fy_reg      <= f_h_reg.zrest ? '0 : fy_sat;
            ratio_i_reg <= f_h_reg.zrest ? '0 : ratio_reg;
            brk_i_reg   <= !f_h_reg.zrest && f_h_reg.brk;
            vres_i_reg  <= !f_h_reg.zrest;
        end
    end

    assign m_tvalid = v_i_reg;
    assign m_tdata  = {7'd0, ratio_i_reg, fy_reg, fx_reg};
    assign m_tuser  = {vres_i_reg, brk_i_reg};

    // ---------------- assertions ----------------
    `SBF_ASSERT_NOW(a_brk_needs_valid, m_tvalid && m_tuser[0], m_tuser[1])
    `SBF_ASSERT_NOW(a_invalid_is_zero, m_tvalid && !m_tuser[1], m_tdata == '0)
    `SBF_ASSERT_NOW(a_brk_ratio_full, m_tvalid && m_tuser[0], m_tdata[96:80] == 17'h10000)
    `SBF_ASSERT_NEXT(a_stall_freezes, !en,
        $stable({v_a_reg, v_b_reg, v_c_reg, v_d_reg, v_sq_reg, v_e_reg, v_f_reg, v_dv_reg,
                 v_h_reg}))

endmodule

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the spring beam force pipeline: a directed table,
// then random beams over several register settings and handshake idling mixes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    typedef struct packed {
        logic [39:0] fx;
        logic [39:0] fy;
        logic [16:0] ratio;
        logic        brk;
        logic        vld;
    } beam_res_t;

    typedef struct {
        logic [23:0] ax, ay, bx, by, rest;
        logic [1:0]  mode;
        logic        typed;
        beam_res_t   res;
    } beam_row_t;

    // an index that maps to no register
    localparam logic [sbf_pkg::CFG_IDX_W-1:0] REG_UNKNOWN = 8'd200;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic [119:0]  s_tdata = '0;
    logic [1:0]    s_tuser = '0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [103:0]  m_tdata;
    logic [1:0]    m_tuser;
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic          cfg_valid = 1'b0;
    logic          cfg_ready;
    logic [sbf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [sbf_pkg::CFG_DAT_W-1:0] cfg_data = '0;

    // register mirror
    logic [23:0] stiff_r = 24'd256000;
    logic [23:0] brk_r   = 24'd512000;
    logic [15:0] mpl_r   = 16'd655;
    logic [23:0] grav_r  = 24'd2511;

    beam_res_t     force_q[$];
    logic          typed_flag_q[$];
    beam_res_t     typed_res_q[$];
    int            errors = 0;
    int            send_idle_pct = 0;
    int            recv_stall_pct = 0;
    bit            hold_req = 1'b0;
    int            quiet_cycles = 0;

    spring_beam_force_with_break u_dut (.*);

    always #2 aclk = ~aclk;

    function automatic longint unsigned isqrt(input longint unsigned n);
        longint unsigned root, bitv;
        root = 0;
        bitv = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (n >= root + bitv) begin
                n = n - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic longint sat40(input longint v);
        if (v > 64'sd549755813887) return 64'sd549755813887;
        if (v < -64'sd549755813888) return -64'sd549755813888;
        return v;
    endfunction

    function automatic beam_res_t beam_force(input logic [119:0] d, input logic [1:0] mode);
        longint ax, ay, bx, by, g, half, sx, sy, fx, fy;
        longint unsigned rest, adx, ady, len, sabs, mag, magsat, ux, uy, mass, hw;
        bit nx, ny, ns, ng;
        beam_res_t r;
        r = '0;
        ax = longint'($signed(d[23:0]));
        ay = longint'($signed(d[47:24]));
        bx = longint'($signed(d[71:48]));
        by = longint'($signed(d[95:72]));
        rest = d[119:96];
        if (rest == 0) return r;
        nx = ax < bx;
        ny = ay < by;
        adx = nx ? bx - ax : ax - bx;
        ady = ny ? by - ay : ay - by;
        len = isqrt(adx * adx + ady * ady);
        mag = 0;
        sx = 0;
        sy = 0;
        if (len != 0) begin
            ns = len < rest;
            sabs = ns ? rest - len : len - rest;
            mag = (longint'(stiff_r) * sabs) >> 8;
            magsat = (mag > 64'd549755813887) ? 64'd549755813887 : mag;
            ux = (adx << 16) / len;
            uy = (ady << 16) / len;
            sx = longint'((magsat * ux) >> 16);
            sy = longint'((magsat * uy) >> 16);
            if (ns != nx) sx = -sx;
            if (ns != ny) sy = -sy;
        end
        if (brk_r != 0) begin
            if (mag >= brk_r) begin
                r.ratio = 17'd65536;
                r.brk = 1'b1;
            end else begin
                r.ratio = 17'((mag << 16) / brk_r);
            end
        end
        mass = (longint'(mpl_r) * rest) >> 16;
        g = longint'($signed(grav_r));
        ng = g < 0;
        hw = (mass * longint'(ng ? -g : g)) >> 9;
        half = ng ? -longint'(hw) : longint'(hw);
        fx = 0;
        fy = 0;
        if (mode == sbf_pkg::MODE_END_A) begin
            fx = sat40(-sx);
            fy = sat40(-sy + half);
        end else if (mode == sbf_pkg::MODE_END_B) begin
            fx = sat40(sx);
            fy = sat40(sy + half);
        end
        r.fx = fx[39:0];
        r.fy = fy[39:0];
        r.vld = 1'b1;
        return r;
    endfunction

    // receiver: random stalls plus one long hold on request
    always @(negedge aclk) begin
        static int hold_left = 0;
        if (hold_req) begin
            hold_req = 1'b0;
            hold_left = 400;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // monitor: predict on input words, check output words, watchdog
    always @(posedge aclk) begin
        beam_res_t got, want;
        if (aresetn) begin
            quiet_cycles++;
            if (cfg_valid && cfg_ready) begin
                quiet_cycles = 0;
                case (cfg_index)
                    sbf_pkg::REG_STIFFNESS:   stiff_r = cfg_data;
                    sbf_pkg::REG_BREAK_FORCE: brk_r = cfg_data;
                    sbf_pkg::REG_MASS_PER_L:  mpl_r = cfg_data[15:0];
                    sbf_pkg::REG_GRAVITY:     grav_r = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                quiet_cycles = 0;
                want = beam_force(s_tdata, s_tuser);
                if (typed_flag_q.size() > 0) begin
                    if (typed_flag_q.pop_front()) want = typed_res_q.pop_front();
                    else void'(typed_res_q.pop_front());
                end
                force_q.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                quiet_cycles = 0;
                got = {m_tdata[39:0], m_tdata[79:40], m_tdata[96:80], m_tuser[0], m_tuser[1]};
                if (force_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected word %h", $time, got);
                end else begin
                    want = force_q.pop_front();
                    if (got.fx !== want.fx)
                        $display("%0t: force_x exp %h act %h", $time, want.fx, got.fx);
                    if (got.fy !== want.fy)
                        $display("%0t: force_y exp %h act %h", $time, want.fy, got.fy);
                    if (got.ratio !== want.ratio)
                        $display("%0t: ratio exp %h act %h", $time, want.ratio, got.ratio);
                    if (got.brk !== want.brk)
                        $display("%0t: broken exp %b act %b", $time, want.brk, got.brk);
                    if (got.vld !== want.vld)
                        $display("%0t: valid_res exp %b act %b", $time, want.vld, got.vld);
                    if (got !== want) errors++;
                end
            end
            if (quiet_cycles >= 5000) begin
                $display("tb failed");
                $finish;
            end
        end
    end

    task automatic send_beam(input logic [119:0] d, input logic [1:0] mode);
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tdata  <= d;
        s_tuser  <= mode;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain;
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (force_q.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [sbf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [23:0] val);
        @(negedge aclk);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [23:0] rand_coord(input int span);
        if (span == 0) return 24'($urandom);
        return 24'($signed($urandom_range(0, 2 * span)) - span);
    endfunction

    beam_row_t rows[$];
    logic [23:0] cfg_set[8][4] = '{
        '{24'd256000, 24'd512000, 24'd655,   24'd2511},
        '{24'hFFFFFF, 24'd0,      24'hFFFF,  24'h800000},
        '{24'd0,      24'hFFFFFF, 24'd0,     24'h7FFFFF},
        '{24'd1,      24'd1,      24'd1,     24'hFFFFFF},
        '{24'd12345,  24'd70000,  24'd3000,  -24'sd2511},
        '{24'hFFFFFF, 24'hFFFFFF, 24'hFFFF,  24'h7FFFFF},
        '{24'd512,    24'd256,    24'd40000, 24'd100},
        '{24'd256000, 24'd512000, 24'd655,   24'd2511}
    };

    function automatic beam_row_t mk(input logic [23:0] ax, ay, bx, by, rest,
                                     input logic [1:0] mode, input logic typed,
                                     input beam_res_t res);
        beam_row_t r;
        r.ax = ax; r.ay = ay; r.bx = bx; r.by = by; r.rest = rest;
        r.mode = mode; r.typed = typed; r.res = res;
        return r;
    endfunction

    initial begin
        logic [23:0] ax, ay, bx, by, rest;
        logic [1:0]  mode;
        int span;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed table, default registers
        // zero rest length: everything zero, valid_res low
        rows.push_back(mk(24'd1000, 24'd5, 24'd0, 24'd0, 24'd0, sbf_pkg::MODE_END_B, 1, '0));
        // zero length, rest 1.0: only the half weight on y
        rows.push_back(mk(24'd77, 24'd77, 24'd77, 24'd77, 24'd256, sbf_pkg::MODE_END_B, 1,
                          '{fx: 40'd0, fy: 40'd9, ratio: 17'd0, brk: 1'b0, vld: 1'b1}));
        rows.push_back(mk(24'd77, 24'd77, 24'd77, 24'd77, 24'd256, sbf_pkg::MODE_END_A, 1,
                          '{fx: 40'd0, fy: 40'd9, ratio: 17'd0, brk: 1'b0, vld: 1'b1}));
        // neither end: forces zero
        rows.push_back(mk(24'd0, 24'd0, 24'd0, 24'd0, 24'd256, sbf_pkg::MODE_NEITHER, 1,
                          '{fx: 40'd0, fy: 40'd0, ratio: 17'd0, brk: 1'b0, vld: 1'b1}));
        rows.push_back(mk(24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h800000, 24'hFFFFFF,
                          sbf_pkg::MODE_END_A, 0, '0));
        rows.push_back(mk(24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'hFFFFFF,
                          sbf_pkg::MODE_END_B, 0, '0));
        rows.push_back(mk(24'h800000, 24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'd1,
                          sbf_pkg::MODE_END_B, 0, '0));
        rows.push_back(mk(24'h7FFFFF, 24'd0, 24'h800000, 24'd0, 24'd1,
                          sbf_pkg::MODE_UNUSED, 0, '0));
        rows.push_back(mk(24'd512, 24'd0, 24'd0, 24'd0, 24'd256, sbf_pkg::MODE_END_A, 0, '0));
        rows.push_back(mk(24'd0, 24'd512, 24'd0, 24'd0, 24'd256, sbf_pkg::MODE_END_B, 0, '0));
        rows.push_back(mk(24'd100, 24'd0, 24'd0, 24'd0, 24'd256, sbf_pkg::MODE_END_B, 0, '0));
        rows.push_back(mk(24'd0, -24'sd300, 24'd0, 24'd0, 24'd256, sbf_pkg::MODE_END_A, 0,
                          '0));
        rows.push_back(mk(24'd256, 24'd256, 24'd0, 24'd0, 24'd362, sbf_pkg::MODE_END_B, 0,
                          '0));
        rows.push_back(mk(24'd3000, 24'd4000, 24'd0, 24'd0, 24'd256, sbf_pkg::MODE_END_A, 0,
                          '0));
        rows.push_back(mk(24'd0, 24'd0, 24'd3, 24'd4, 24'hFFFFFF, sbf_pkg::MODE_END_B, 0,
                          '0));
        rows.push_back(mk(24'd0, 24'd0, 24'd0, 24'd0, 24'hFFFFFF, sbf_pkg::MODE_UNUSED, 0,
                          '0));
        foreach (rows[i]) begin
            typed_flag_q.push_back(rows[i].typed);
            typed_res_q.push_back(rows[i].res);
            send_beam({rows[i].rest, rows[i].by, rows[i].bx, rows[i].ay, rows[i].ax},
                      rows[i].mode);
        end
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            write_reg(sbf_pkg::REG_STIFFNESS, cfg_set[ph][0]);
            write_reg(sbf_pkg::REG_BREAK_FORCE, cfg_set[ph][1]);
            write_reg(sbf_pkg::REG_MASS_PER_L, cfg_set[ph][2]);
            write_reg(sbf_pkg::REG_GRAVITY, cfg_set[ph][3]);
            // unknown index is ignored
            write_reg(REG_UNKNOWN, 24'hABCDEF);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
                default: begin send_idle_pct = 26; recv_stall_pct = 26; end
            endcase
            for (int k = 0; k < 240; k++) begin
                if (ph == 2 && k == 20) hold_req = 1'b1;
                if (k == 120) begin
                    // sender pause until the pipe is empty
                    @(negedge aclk);
                    s_tvalid <= 1'b0;
                    while (force_q.size() != 0) @(posedge aclk);
                end
                case ($urandom_range(0, 3))
                    0: span = 0;
                    1: span = 4096;
                    2: span = 60000;
                    default: span = 300;
                endcase
                ax = rand_coord(span);
                ay = rand_coord(span);
                if ($urandom_range(0, 9) == 0) begin
                    bx = ax;
                    by = ay;
                end else begin
                    bx = rand_coord(span);
                    by = rand_coord(span);
                end
                case ($urandom_range(0, 15))
                    0: rest = 24'd0;
                    1, 2, 3: rest = 24'($urandom);
                    default: rest = 24'($urandom_range(1, (span == 0) ? 24'hFFFFFF : 3 * span));
                endcase
                mode = ($urandom_range(0, 9) == 0)
                       ? 2'($urandom_range(sbf_pkg::MODE_NEITHER, sbf_pkg::MODE_UNUSED))
                       : 2'($urandom_range(sbf_pkg::MODE_END_A, sbf_pkg::MODE_END_B));
                send_beam({rest, by, bx, ay, ax}, mode);
            end
            drain();
        end

        if (errors == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
